// ===== sv/bkd_pkg.sv =====
`timescale 1ns / 1ps
// bkd_pkg: shared types and constants of the ball kick detector.
// No dependencies; imported by every bkd module.
package bkd_pkg;

	// Frame window
	localparam int HIST_LEN = 3;
	localparam int MID_IDX  = HIST_LEN / 2;

	// Result queue
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Squared distance search
	localparam int                DIST_W   = 34;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [15:0] ACCEL_LIMIT_RST = 16'd625;

	// Item kinds and team codes
	localparam logic FUNC_BALL   = 1'b0;
	localparam logic FUNC_ROBOT  = 1'b1;
	localparam logic TEAM_YELLOW = 1'b0;
	localparam logic TEAM_BLUE   = 1'b1;

	typedef struct packed {
		logic               found;
		logic [3:0]         id;
		logic               team;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} robot_t;

	typedef struct packed {
		logic               filled;
		logic signed [15:0] ball_x;
		logic signed [15:0] ball_y;
		logic               ball_valid;
		logic [31:0]        stamp;
		robot_t             nearest;
	} frame_t;

	typedef struct packed {
		logic        kick;
		logic [31:0] kick_time;
		robot_t      robot;
	} result_t;

	localparam robot_t ROBOT_NONE = '0;

endpackage

// ===== sv/bkd_cell.sv =====
`timescale 1ns / 1ps
// bkd_cell: one entry of the frame window; loads its newer neighbor on a shift.
// Depends on bkd_pkg.
module bkd_cell import bkd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  frame_t din,
	output frame_t q
);

	frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (shift) begin
			frame_q <= din;
		end
	end

	assign q = frame_q;

endmodule

// ===== sv/bkd_nearest.sv =====
`timescale 1ns / 1ps
// bkd_nearest: open-frame ball register and nearest-robot search by squared distance.
// Depends on bkd_pkg.
module bkd_nearest import bkd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_acc,
	input  logic               func,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic               valid_req,
	input  logic [31:0]        frame_time,
	input  logic [3:0]         robot_id,
	input  logic               team,
	input  logic               last,
	output logic               push,
	output frame_t             push_frame
);

	logic signed [15:0] cur_x_q, cur_y_q;
	logic               cur_valid_q;
	logic [31:0]        cur_time_q;
	logic [DIST_W-1:0]  best_dist_q;
	robot_t             best_robot_q;

	logic               v_s1;
	logic               func_s1, last_s1, rvalid_s1;
	robot_t             robot_s1;
	logic [31:0]        sq_x_s1, sq_y_s1;

	logic signed [16:0] dx, dy;
	logic signed [33:0] prod_x, prod_y;
	logic [DIST_W-1:0]  sq_dist;
	logic               take;
	logic [DIST_W-1:0]  eff_dist;
	robot_t             eff_robot;

	// squares against the current ball, formed in the accepting cycle
	assign dx     = $signed({cur_x_q[15], cur_x_q}) - $signed({pos_x[15], pos_x});
	assign dy     = $signed({cur_y_q[15], cur_y_q}) - $signed({pos_y[15], pos_y});
	assign prod_x = dx * dx;
	assign prod_y = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_time_q  <= '0;
		end else begin
			v_s1 <= in_acc;
			if (in_acc && func == FUNC_BALL) begin
				cur_x_q     <= pos_x;
				cur_y_q     <= pos_y;
				cur_valid_q <= valid_req;
				cur_time_q  <= frame_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1        <= func;
			last_s1        <= last;
			rvalid_s1      <= valid_req;
			robot_s1.found <= 1'b1;
			robot_s1.id    <= robot_id;
			robot_s1.team  <= team;
			robot_s1.x     <= pos_x;
			robot_s1.y     <= pos_y;
			sq_x_s1        <= prod_x[31:0];
			sq_y_s1        <= prod_y[31:0];
		end
	end

	// compare and update; yellow wins a tie against a stored blue robot
	always_comb begin
		sq_dist = DIST_W'({1'b0, sq_x_s1} + {1'b0, sq_y_s1});
		take = (sq_dist < best_dist_q) ||
			((sq_dist == best_dist_q) && (!best_robot_q.found ||
			(best_robot_q.team == TEAM_BLUE && robot_s1.team == TEAM_YELLOW)));
		if (func_s1 == FUNC_BALL) begin
			eff_dist  = DIST_MAX;
			eff_robot = ROBOT_NONE;
		end else if (func_s1 == FUNC_ROBOT && rvalid_s1 && take) begin
			eff_dist  = sq_dist;
			eff_robot = robot_s1;
		end else begin
			eff_dist  = best_dist_q;
			eff_robot = best_robot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q  <= DIST_MAX;
			best_robot_q <= ROBOT_NONE;
		end else if (v_s1) begin
			if (last_s1) begin
				best_dist_q  <= DIST_MAX;
				best_robot_q <= ROBOT_NONE;
			end else begin
				best_dist_q  <= eff_dist;
				best_robot_q <= eff_robot;
			end
		end
	end

	assign push                  = v_s1 && last_s1;
	assign push_frame.filled     = 1'b1;
	assign push_frame.ball_x     = cur_x_q;
	assign push_frame.ball_y     = cur_y_q;
	assign push_frame.ball_valid = cur_valid_q;
	assign push_frame.stamp      = cur_time_q;
	assign push_frame.nearest    = eff_robot;

endmodule

// ===== sv/bkd_detect.sv =====
`timescale 1ns / 1ps
// bkd_detect: three-stage kick test over the frame window (differences, squares, compare).
// Depends on bkd_pkg.
module bkd_detect import bkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        eval,
	input  frame_t      win [HIST_LEN],
	input  logic [15:0] accel_limit,
	output logic        res_v,
	output result_t     res
);

	logic               all_valid;
	logic signed [16:0] sx, sy, ex, ey;
	logic signed [17:0] ax, ay;

	logic               v_s1, ok_s1;
	logic signed [16:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [17:0] ax_s1, ay_s1;
	logic [15:0]        lim_s1;
	logic [31:0]        stamp_s1;
	robot_t             robot_s1;

	logic signed [33:0] psx, psy, pex, pey;
	logic signed [35:0] pax, pay;
	logic               v_s2, ok_s2;
	logic [31:0]        sx2_s2, sy2_s2, ex2_s2, ey2_s2, lim2_s2;
	logic [34:0]        ax2_s2, ay2_s2;
	logic [31:0]        stamp_s2;
	robot_t             robot_s2;

	logic [35:0]        acc2;
	logic [32:0]        s2, e2;
	logic               kick;

	always_comb begin
		all_valid = 1'b1;
		for (int i = 0; i < HIST_LEN; i++) begin
			all_valid = all_valid & win[i].ball_valid;
		end
	end

	assign sx = $signed({win[1].ball_x[15], win[1].ball_x}) -
		$signed({win[0].ball_x[15], win[0].ball_x});
	assign sy = $signed({win[1].ball_y[15], win[1].ball_y}) -
		$signed({win[0].ball_y[15], win[0].ball_y});
	assign ex = $signed({win[HIST_LEN-1].ball_x[15], win[HIST_LEN-1].ball_x}) -
		$signed({win[HIST_LEN-2].ball_x[15], win[HIST_LEN-2].ball_x});
	assign ey = $signed({win[HIST_LEN-1].ball_y[15], win[HIST_LEN-1].ball_y}) -
		$signed({win[HIST_LEN-2].ball_y[15], win[HIST_LEN-2].ball_y});
	assign ax = $signed({ex[16], ex}) - $signed({sx[16], sx});
	assign ay = $signed({ey[16], ey}) - $signed({sy[16], sy});

	assign psx = sx_s1 * sx_s1;
	assign psy = sy_s1 * sy_s1;
	assign pex = ex_s1 * ex_s1;
	assign pey = ey_s1 * ey_s1;
	assign pax = ax_s1 * ax_s1;
	assign pay = ay_s1 * ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			res_v <= 1'b0;
		end else begin
			v_s1  <= eval;
			v_s2  <= v_s1;
			res_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= win[0].filled && all_valid;
		sx_s1    <= sx;
		sy_s1    <= sy;
		ex_s1    <= ex;
		ey_s1    <= ey;
		ax_s1    <= ax;
		ay_s1    <= ay;
		lim_s1   <= accel_limit;
		stamp_s1 <= win[MID_IDX].stamp;
		robot_s1 <= win[MID_IDX].nearest;

		ok_s2    <= ok_s1;
		sx2_s2   <= psx[31:0];
		sy2_s2   <= psy[31:0];
		ex2_s2   <= pex[31:0];
		ey2_s2   <= pey[31:0];
		ax2_s2   <= pax[34:0];
		ay2_s2   <= pay[34:0];
		lim2_s2  <= lim_s1 * lim_s1;
		stamp_s2 <= stamp_s1;
		robot_s2 <= robot_s1;
	end

	assign acc2 = {1'b0, ax2_s2} + {1'b0, ay2_s2};
	assign s2   = {1'b0, sx2_s2} + {1'b0, sy2_s2};
	assign e2   = {1'b0, ex2_s2} + {1'b0, ey2_s2};
	assign kick = ok_s2 && (acc2 > {4'b0, lim2_s2}) && (s2 < e2);

	always_ff @(posedge clk) begin
		res.kick      <= kick;
		res.kick_time <= kick ? stamp_s2 : '0;
		res.robot     <= (kick && robot_s2.found) ? robot_s2 : ROBOT_NONE;
	end

endmodule

// ===== sv/ball_kick_detector_core.sv =====
`timescale 1ns / 1ps
// ball_kick_detector_core: top level of the ball kick detector.
// Depends on bkd_pkg, bkd_nearest, bkd_cell, bkd_detect.

// The detector takes one request per clock while in_ready is high: a ball
// request opens a frame, robot requests follow, and the request with last
// set closes it and yields exactly one result. The rate is set by the
// nearest-robot search, whose squared-distance compare updates the running
// best for each request; the distance squares are formed in the accepting
// cycle and compared in the next one.
// A closed frame shifts into a row of window cells, and the kick test runs
// over three more stages (differences, squares, compare) before its result
// enters the output queue. The queue holds eight results; in_ready drops
// only while eight results are pending in the pipeline and queue together,
// so a stalled consumer never loses a result. The user must write accel_limit
// through cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
module ball_kick_detector_core import bkd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic               valid_req,
	input  logic [31:0]        frame_time,
	input  logic [3:0]         robot_id,
	input  logic               team,
	input  logic               last,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kick,
	output logic [31:0]        kick_time,
	output logic               robot_found,
	output logic [3:0]         kicker_id,
	output logic               kicker_team,
	output logic signed [15:0] kicker_x,
	output logic signed [15:0] kicker_y,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);

	logic [15:0]          accel_limit_q;
	logic                 in_acc, out_acc;
	logic                 push;
	frame_t               push_frame;
	frame_t               win [HIST_LEN];
	logic                 win_new_q;
	logic                 res_v;
	result_t              res;

	result_t              fifo_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q, pend_q;
	result_t              head;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// hold the kick threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q <= ACCEL_LIMIT_RST;
		end else if (cfg_wr_en) begin
			accel_limit_q <= cfg_wr_data;
		end
	end

	// open frame and nearest-robot search
	bkd_nearest u_nearest (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_acc     (in_acc),
		.func       (func),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.valid_req  (valid_req),
		.frame_time (frame_time),
		.robot_id   (robot_id),
		.team       (team),
		.last       (last),
		.push       (push),
		.push_frame (push_frame)
	);

	// window: the newest cell loads the closed frame, each other cell loads its
	// newer neighbor; cell 0 holds the oldest frame, filled marks a full window
	for (genvar i = 0; i < HIST_LEN; i++) begin : g_win
		if (i == HIST_LEN - 1) begin : g_newest
			bkd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (push),
				.din    (push_frame),
				.q      (win[i])
			);
		end else begin : g_older
			bkd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (push),
				.din    (win[i+1]),
				.q      (win[i])
			);
		end
	end

	// evaluate the window in the cycle after it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_new_q <= 1'b0;
		end else begin
			win_new_q <= push;
		end
	end

	bkd_detect u_detect (
		.clk         (clk),
		.arst_n      (arst_n),
		.eval        (win_new_q),
		.win         (win),
		.accel_limit (accel_limit_q),
		.res_v       (res_v),
		.res         (res)
	);

	// result queue; pend_q counts closing requests not yet delivered, so the
	// queue always has room for everything in flight
	assign in_ready  = pend_q < RES_CNT_W'(RES_DEPTH);
	assign out_valid = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (res_v) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({res_v, out_acc})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			case ({in_acc && last, out_acc})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign head        = fifo_q[rd_ptr_q];
	assign kick        = head.kick;
	assign kick_time   = head.kick_time;
	assign robot_found = head.robot.found;
	assign kicker_id   = head.robot.id;
	assign kicker_team = head.robot.team;
	assign kicker_x    = head.robot.x;
	assign kicker_y    = head.robot.y;

	// a result never arrives at a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |-> (cnt_q < RES_CNT_W'(RES_DEPTH)))
		else $error("result written into a full queue");

	// queued results are a subset of pending ones
	a_pend_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pend_q)
		else $error("queue holds more results than pending requests");

	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= RES_CNT_W'(RES_DEPTH))
		else $error("pending count above queue depth");

	// a result without a kick carries no time and no robot
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kick) |-> (kick_time == '0 && !robot_found))
		else $error("non-kick result carries kick data");

	// a result traces back to a frame close through win_new_q and the detect stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |-> $past(push, 4))
		else $error("result without a matching frame close");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for ball_kick_detector_core, with a frame-window predictor.
// Depends on bkd_pkg and ball_kick_detector_core; needs no other files.
module tb;
	import bkd_pkg::*;

	localparam int HOLD_CYCLES = 400;

	// Frame-window predictor and result store. It tracks the open frame's
	// nearest robot, shifts closed frames into the window and queues one
	// expected result per closing request.
	class kick_scoreboard;
		logic [15:0] accel_limit;
		frame_t      window [HIST_LEN];
		int          frames_held;
		frame_t      open_frame;
		longint      best_dist;
		robot_t      best_robot;
		result_t     expected_q [$];
		int          mismatches;
		int          results_checked;
		int          kicks_checked;

		function new();
			accel_limit = ACCEL_LIMIT_RST;
			foreach (window[i]) window[i] = '0;
			frames_held     = 0;
			open_frame      = '0;
			mismatches      = 0;
			results_checked = 0;
			kicks_checked   = 0;
			restart_search();
		endfunction

		function void restart_search();
			best_dist  = longint'(DIST_MAX);
			best_robot = ROBOT_NONE;
		endfunction

		function void set_limit(logic [15:0] value);
			accel_limit = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Second difference against the threshold, end step against start step.
		function bit window_kicks();
			longint sx, sy, ex, ey, ax, ay, lim2;
			sx   = longint'(window[1].ball_x) - longint'(window[0].ball_x);
			sy   = longint'(window[1].ball_y) - longint'(window[0].ball_y);
			ex   = longint'(window[HIST_LEN-1].ball_x) - longint'(window[HIST_LEN-2].ball_x);
			ey   = longint'(window[HIST_LEN-1].ball_y) - longint'(window[HIST_LEN-2].ball_y);
			ax   = ex - sx;
			ay   = ey - sy;
			lim2 = longint'(accel_limit) * longint'(accel_limit);
			return (ax * ax + ay * ay > lim2) && (sx * sx + sy * sy < ex * ex + ey * ey);
		endfunction

		function void note_request(logic f, logic signed [15:0] px, logic signed [15:0] py,
			logic v, logic [31:0] ft, logic [3:0] rid, logic tm, logic lst);
			longint  dx, dy, sq_dist;
			bit      take, all_valid;
			result_t res;
			if (f == FUNC_BALL) begin
				open_frame.ball_x     = px;
				open_frame.ball_y     = py;
				open_frame.ball_valid = v;
				open_frame.stamp      = ft;
				restart_search();
			end else if (v) begin
				dx      = longint'(open_frame.ball_x) - longint'(px);
				dy      = longint'(open_frame.ball_y) - longint'(py);
				sq_dist = dx * dx + dy * dy;
				take = sq_dist < best_dist ||
					(sq_dist == best_dist && best_robot.found &&
					 best_robot.team == TEAM_BLUE && tm == TEAM_YELLOW) ||
					(!best_robot.found && sq_dist == best_dist);
				if (take) begin
					best_dist        = sq_dist;
					best_robot.found = 1'b1;
					best_robot.id    = rid;
					best_robot.team  = tm;
					best_robot.x     = px;
					best_robot.y     = py;
				end
			end
			if (!lst)
				return;
			for (int i = 0; i < HIST_LEN - 1; i++)
				window[i] = window[i + 1];
			window[HIST_LEN-1]         = open_frame;
			window[HIST_LEN-1].filled  = 1'b1;
			window[HIST_LEN-1].nearest = best_robot;
			if (frames_held < HIST_LEN)
				frames_held++;
			restart_search();
			res = '0;
			if (frames_held >= HIST_LEN) begin
				all_valid = 1'b1;
				foreach (window[i])
					if (!window[i].ball_valid)
						all_valid = 1'b0;
				if (all_valid && window_kicks()) begin
					res.kick      = 1'b1;
					res.kick_time = window[MID_IDX].stamp;
					res.robot     = window[MID_IDX].nearest;
				end
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no frame pending: kick=%0b time=%h", $realtime,
						got.kick, got.kick_time);
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			results_checked++;
			if (want.kick)
				kicks_checked++;
			bad = (got.kick !== want.kick) || (got.kick_time !== want.kick_time) ||
				(got.robot.found !== want.robot.found) || (got.robot.id !== want.robot.id) ||
				(got.robot.team !== want.robot.team) || (got.robot.x !== want.robot.x) ||
				(got.robot.y !== want.robot.y);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %0d mismatch", $realtime, results_checked);
					$display("  expected kick=%0b time=%h found=%0b id=%0d team=%0b x=%0d y=%0d",
						want.kick, want.kick_time, want.robot.found, want.robot.id,
						want.robot.team, want.robot.x, want.robot.y);
					$display("  actual   kick=%0b time=%h found=%0b id=%0d team=%0b x=%0d y=%0d",
						got.kick, got.kick_time, got.robot.found, got.robot.id,
						got.robot.team, got.robot.x, got.robot.y);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               valid_req;
	logic [31:0]        frame_time;
	logic [3:0]         robot_id;
	logic               team;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic               kick;
	logic [31:0]        kick_time;
	logic               robot_found;
	logic [3:0]         kicker_id;
	logic               kicker_team;
	logic signed [15:0] kicker_x;
	logic signed [15:0] kicker_y;
	logic               cfg_wr_en;
	logic [15:0]        cfg_wr_data;

	kick_scoreboard sb;

	// Run-wide knobs shared by the producer and consumer processes.
	bit          no_idle;
	bit          hold_req;
	int          req_count;
	int          frame_count;
	int          cfg_count;
	int          traj_x, traj_y, vel_x, vel_y;
	logic [31:0] clock_stamp;

	ball_kick_detector_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.valid_req   (valid_req),
		.frame_time  (frame_time),
		.robot_id    (robot_id),
		.team        (team),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kick        (kick),
		.kick_time   (kick_time),
		.robot_found (robot_found),
		.kicker_id   (kicker_id),
		.kicker_team (kicker_team),
		.kicker_x    (kicker_x),
		.kicker_y    (kicker_y),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (every gap and stall at maximum).
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one request and hold it until taken. An optional idle burst goes
	// first; valid is never dropped between back-to-back requests.
	task automatic send_req(input logic f, input logic signed [15:0] px,
		input logic signed [15:0] py, input logic v, input logic [31:0] ft,
		input logic [3:0] rid, input logic tm, input logic lst);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		pos_x      <= px;
		pos_y      <= py;
		valid_req  <= v;
		frame_time <= ft;
		robot_id   <= rid;
		team       <= tm;
		last       <= lst;
		do @(posedge clk); while (!in_ready);
		sb.note_request(f, px, py, v, ft, rid, tm, lst);
		req_count++;
		if (lst)
			frame_count++;
	endtask

	// Drain, let the kick pipeline settle, then write the threshold.
	task automatic set_accel_limit(input logic [15:0] value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(value);
		cfg_count++;
	endtask

	// One camera frame with random content. The ball mostly follows a
	// trajectory whose velocity changes now and then, so real kicks show up;
	// a few frames are abandoned half-way or carry robots only.
	task automatic play_frame();
		int                 n_bots, shape, k;
		logic signed [15:0] bx, by, rx, ry;
		shape = $urandom_range(0, 19);
		if ($urandom_range(0, 5) == 0) begin
			vel_x = int'($urandom_range(0, 1600)) - 800;
			vel_y = int'($urandom_range(0, 1600)) - 800;
		end
		traj_x += vel_x;
		traj_y += vel_y;
		if (traj_x > 30000 || traj_x < -30000)
			traj_x = 0;
		if (traj_y > 30000 || traj_y < -30000)
			traj_y = 0;
		if ($urandom_range(0, 11) == 0) begin
			bx = 16'($urandom);
			by = 16'($urandom);
		end else begin
			bx = 16'(traj_x);
			by = 16'(traj_y);
		end
		clock_stamp = ($urandom_range(0, 15) == 0) ? $urandom
			: clock_stamp + $urandom_range(1, 40);
		n_bots = $urandom_range(0, 4);
		rx = bx;
		ry = by;
		// Abandon a frame: ball and one robot, then the real ball reopens it.
		if (shape == 0) begin
			send_req(FUNC_BALL, 16'($urandom), 16'($urandom), 1'b1, $urandom,
				4'($urandom), 1'($urandom), 1'b0);
			send_req(FUNC_ROBOT, 16'($urandom), 16'($urandom), 1'b1, $urandom,
				4'($urandom), 1'($urandom), 1'b0);
		end
		// Robots only: the frame reuses the last ball sample.
		if (shape == 1) begin
			if (n_bots == 0)
				n_bots = 1;
		end else begin
			send_req(FUNC_BALL, bx, by, $urandom_range(0, 9) != 0, clock_stamp,
				4'($urandom), 1'($urandom), n_bots == 0);
		end
		for (k = 0; k < n_bots; k++) begin
			case ($urandom_range(0, 5))
				0: ; // same spot as the previous robot: exact tie
				1: rx = 16'(2 * int'(bx) - int'(rx)); // mirror across the ball: tie
				2: begin
					rx = 16'($urandom);
					ry = 16'($urandom);
				end
				default: begin
					rx = 16'(int'(bx) + int'($urandom_range(0, 3000)) - 1500);
					ry = 16'(int'(by) + int'($urandom_range(0, 3000)) - 1500);
				end
			endcase
			send_req(FUNC_ROBOT, rx, ry, $urandom_range(0, 6) != 0, $urandom,
				4'($urandom), 1'($urandom), k == n_bots - 1);
		end
	endtask

	// Consumer: ready runs and stall bursts, plus one long hold on request so
	// the result queue fills and the block backs up its input.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Check every result taken by the consumer against the oldest expectation.
	always @(posedge clk) begin : watch_results
		result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kick        = kick;
			seen.kick_time   = kick_time;
			seen.robot.found = robot_found;
			seen.robot.id    = kicker_id;
			seen.robot.team  = kicker_team;
			seen.robot.x     = kicker_x;
			seen.robot.y     = kicker_y;
			sb.check_result(seen);
		end
	end

	initial begin
		logic [15:0] limit_plan [8];
		int          phase_base;
		limit_plan = '{16'd0, 16'd65535, 16'd1, 16'd625, 16'd3000, 16'd0, 16'd150, 16'd625};
		limit_plan[5] = 16'($urandom);
		sb          = new();
		no_idle     = 1'b0;
		hold_req    = 1'b0;
		req_count   = 0;
		frame_count = 0;
		cfg_count   = 0;
		traj_x      = 0;
		traj_y      = 0;
		vel_x       = 40;
		vel_y       = -25;
		clock_stamp = 32'd1000;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_BALL;
		pos_x       <= '0;
		pos_y       <= '0;
		valid_req   <= 1'b0;
		frame_time  <= '0;
		robot_id    <= '0;
		team        <= TEAM_YELLOW;
		last        <= 1'b0;
		out_ready   <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_accel_limit(16'd625);

		// Corner positions; at equal distance yellow beats blue.
		send_req(FUNC_BALL, 16'sh8000, 16'sh8000, 1'b1, 32'h0, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sh7FFF, 16'sh7FFF, 1'b1, 32'h0, 4'd15, TEAM_BLUE, 1'b0);
		send_req(FUNC_ROBOT, 16'sh7FFF, 16'sh7FFF, 1'b1, 32'h0, 4'd0, TEAM_YELLOW, 1'b1);
		// Same-team tie keeps the earlier robot, blue never displaces yellow,
		// and an invalid robot still closes the frame.
		send_req(FUNC_BALL, 16'sd0, 16'sd0, 1'b1, 32'hFFFF_FFFF, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd100, 16'sd0, 1'b1, 32'h0, 4'd5, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, -16'sd100, 16'sd0, 1'b1, 32'h0, 4'd6, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd0, 16'sd100, 1'b1, 32'h0, 4'd9, TEAM_BLUE, 1'b0);
		send_req(FUNC_ROBOT, 16'sd1, 16'sd1, 1'b0, 32'h0, 4'd1, TEAM_YELLOW, 1'b1);
		// Ball-only frame fills the window; end step is shorter, so no kick.
		send_req(FUNC_BALL, 16'sh7FFF, 16'sh7FFF, 1'b1, 32'd12345, 4'd0, TEAM_YELLOW, 1'b1);
		// A ball mid-frame drops the unfinished frame.
		send_req(FUNC_BALL, 16'sd10, 16'sd10, 1'b1, 32'd7, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd20, 16'sd20, 1'b1, 32'h0, 4'd2, TEAM_BLUE, 1'b0);
		send_req(FUNC_BALL, 16'sd0, 16'sd0, 1'b1, 32'd100, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd5, 16'sd0, 1'b1, 32'h0, 4'd3, TEAM_BLUE, 1'b1);
		// Robot with no open frame: reuses the previous ball sample.
		send_req(FUNC_ROBOT, 16'sd3, 16'sd4, 1'b1, 32'h0, 4'd4, TEAM_YELLOW, 1'b1);
		// Sudden step after a still ball: kick, kicker from the middle frame.
		send_req(FUNC_BALL, 16'sd3000, 16'sd0, 1'b1, 32'd200, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd2900, 16'sd0, 1'b1, 32'h0, 4'd7, TEAM_BLUE, 1'b1);
		// Invalid ball blocks detection.
		send_req(FUNC_BALL, 16'sd0, 16'sd0, 1'b0, 32'd300, 4'd0, TEAM_YELLOW, 1'b1);
		// Kick whose middle frame has no valid robot.
		send_req(FUNC_BALL, 16'sd0, 16'sd0, 1'b1, 32'd400, 4'd0, TEAM_YELLOW, 1'b1);
		send_req(FUNC_BALL, 16'sd0, 16'sd0, 1'b1, 32'd500, 4'd0, TEAM_YELLOW, 1'b0);
		send_req(FUNC_ROBOT, 16'sd1, 16'sd1, 1'b0, 32'h0, 4'd8, TEAM_YELLOW, 1'b1);
		send_req(FUNC_BALL, -16'sd5000, -16'sd5000, 1'b1, 32'd600, 4'd0, TEAM_YELLOW, 1'b1);

		// Random frames under a sweep of thresholds, extremes included. Hold
		// the consumer off in one phase; drop all idling in the last one.
		for (int ph = 0; ph < 8; ph++) begin
			set_accel_limit(limit_plan[ph]);
			if (ph == 3)
				hold_req = 1'b1;
			if (ph == 7)
				no_idle = 1'b1;
			phase_base = req_count;
			while (req_count - phase_base < 92)
				play_frame();
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d requests in %0d frames across %0d threshold settings.",
			req_count, frame_count, cfg_count);
		$display("Checked %0d results, %0d of them kicks; %0d mismatches.",
			sb.results_checked, sb.kicks_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
